// ----- design/fph_pkg.sv -----
// Shared types, constants and helpers for the fit-policy hole allocator.
// Standalone package; used by every module of the block.
package fph_pkg;

  // Table geometry
  localparam int MAX_HOLES = 16;
  localparam int SIZE_BITS = 16;

  // Port field widths
  localparam int CMD_W   = 1;
  localparam int HIDX_W  = 4;
  localparam int AMT_W   = 16;
  localparam int STAT_W  = 2;
  localparam int REM_W   = 16;
  localparam int FRAG_W  = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Derived widths
  localparam int IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int CNT_W = $clog2(MAX_HOLES + 1);
  localparam int SUM_W = SIZE_BITS + IDX_W;
  localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  localparam logic [FRAG_W-1:0] FRAG_MAX = {FRAG_W{1'b1}};
  localparam int USED_RST = (MAX_HOLES < 16) ? MAX_HOLES : 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REQ  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_COUNT = 2'd1;

  // Placement rules; the unused code behaves as first fit
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_LOADED  = 2'd0,
    STAT_GRANTED = 2'd1,
    STAT_NO_FIT  = 2'd2,
    STAT_REFUSED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // One beat from the table read port into the scan unit
  typedef struct packed {
    logic                 start;
    logic                 vld;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
  } scan_beat_t;

  // Running pick of the scan unit
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] best;
    logic [SUM_W-1:0]     sum;
  } scan_res_t;

  // Saturate the hole total to the fragmentation field
  function automatic logic [FRAG_W-1:0] frag_sat(logic [SUM_W-1:0] s);
    logic [SUM_W+FRAG_W-1:0] wide;
    wide = (SUM_W + FRAG_W)'(s);
    if (wide > (SUM_W + FRAG_W)'(FRAG_MAX)) begin
      return FRAG_MAX;
    end
    return wide[FRAG_W-1:0];
  endfunction

endpackage

// ----- design/fph_scan.sv -----
// Shared compare and accumulate unit: folds one hole per beat into a running pick.
// Depends on fph_pkg.
module fph_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fph_pkg::scan_beat_t        beat_i,
  input  logic [1:0]                 policy_i,
  input  logic [fph_pkg::AMT_W-1:0]  req_i,
  output fph_pkg::scan_res_t         res_o
);

  logic                         found_q, found_d;
  logic [fph_pkg::IDX_W-1:0]     pick_q, pick_d;
  logic [fph_pkg::SIZE_BITS-1:0] best_q, best_d;
  logic [fph_pkg::SUM_W-1:0]     sum_q, sum_d;
  logic [fph_pkg::CMP_W-1:0]     size_ext, req_ext;
  logic                         ge_req, take;

  always_comb begin
    size_ext = fph_pkg::CMP_W'(beat_i.size);
    req_ext  = fph_pkg::CMP_W'(req_i);
    ge_req   = size_ext >= req_ext;
    case (policy_i)
      fph_pkg::POL_BEST:  take = ge_req && (!found_q || beat_i.size < best_q);
      fph_pkg::POL_WORST: take = !found_q || beat_i.size >= best_q;
      default:            take = ge_req && !found_q;
    endcase

    found_d = found_q;
    pick_d  = pick_q;
    best_d  = best_q;
    sum_d   = sum_q;
    if (beat_i.start) begin
      found_d = 1'b0;
      sum_d   = '0;
    end else if (beat_i.vld) begin
      sum_d = sum_q + fph_pkg::SUM_W'(beat_i.size);
      if (take) begin
        found_d = 1'b1;
        pick_d  = beat_i.idx;
        best_d  = beat_i.size;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q <= pick_d;
    best_q <= best_d;
    sum_q  <= sum_d;
  end

  assign res_o = '{found: found_q, pick: pick_q, best: best_q, sum: sum_q};

endmodule

// ----- design/fit_policy_hole_allocator.sv -----
// A load or a refused request gives its result beat in the cycle after acceptance.
// A granted or failed request first scans the hole table, then gives its verdict:
// the hole table has one read port, so the scan unit sees one hole per cycle.
// No item is taken while a request scans; loads go back to back unless results stall.
// Reset: asynchronous, active low; clears the stop flag, policy (first fit) and
// hole count (16). The hole table itself is not cleared.
module fit_policy_hole_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Item channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fph_pkg::CMD_W-1:0]       command_i,
  input  logic [fph_pkg::HIDX_W-1:0]      hole_index_i,
  input  logic [fph_pkg::AMT_W-1:0]       amount_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fph_pkg::STAT_W-1:0]      status_o,
  output logic [fph_pkg::HIDX_W-1:0]      chosen_hole_o,
  output logic [fph_pkg::REM_W-1:0]       remaining_size_o,
  output logic [fph_pkg::FRAG_W-1:0]      fragmentation_o,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fph_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fph_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  // Sequencer state
  fph_pkg::state_e state_q, state_d;
  logic [fph_pkg::CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic stopped_q, stopped_d;

  // Configuration
  logic [1:0]                policy_q;
  logic [fph_pkg::CNT_W-1:0] used_q;

  // Request size, held for the whole scan
  logic [fph_pkg::AMT_W-1:0] req_q;

  // Hole table: one write port, one registered read port
  logic [fph_pkg::SIZE_BITS-1:0] hole_mem_q [fph_pkg::MAX_HOLES];
  logic                          mem_we;
  logic [fph_pkg::IDX_W-1:0]     mem_waddr;
  logic [fph_pkg::SIZE_BITS-1:0] mem_wdata;
  logic                          rd_en;
  logic                          rd_vld_q;
  logic [fph_pkg::IDX_W-1:0]     rd_idx_q;
  logic [fph_pkg::SIZE_BITS-1:0] rd_data_q;

  // Output register
  logic                           out_valid_q, out_valid_d;
  fph_pkg::status_e               status_q, status_d;
  logic [fph_pkg::HIDX_W-1:0]     hole_q, hole_d;
  logic [fph_pkg::REM_W-1:0]      rem_q, rem_d;
  logic [fph_pkg::FRAG_W-1:0]     frag_q, frag_d;

  fph_pkg::scan_beat_t beat;
  fph_pkg::scan_res_t  res;
  logic                scan_start;
  logic                out_free;
  logic                in_fire;
  logic                load_ok;
  logic                fits;
  logic [fph_pkg::SIZE_BITS-1:0] shrunk;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == fph_pkg::ST_IDLE) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // A load beyond the table is dropped but still answered
  assign load_ok = int'(hole_index_i) < fph_pkg::MAX_HOLES;

  // The pick must cover the request; worst fit may settle on a hole too small
  assign fits = res.found &&
                (fph_pkg::CMP_W'(res.best) >= fph_pkg::CMP_W'(req_q));
  assign shrunk = fph_pkg::SIZE_BITS'(fph_pkg::CMP_W'(res.best) -
                                      fph_pkg::CMP_W'(req_q));

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    stopped_d   = stopped_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    hole_d      = hole_q;
    rem_d       = rem_q;
    frag_d      = frag_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    rd_en       = 1'b0;
    scan_start  = 1'b0;

    unique case (state_q)
      fph_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (command_i == fph_pkg::CMD_LOAD) begin
            // Write the hole, echo it back, and release a stopped block
            stopped_d   = 1'b0;
            out_valid_d = 1'b1;
            status_d    = fph_pkg::STAT_LOADED;
            hole_d      = hole_index_i;
            frag_d      = '0;
            if (load_ok) begin
              mem_we    = 1'b1;
              mem_waddr = fph_pkg::IDX_W'(hole_index_i);
              mem_wdata = fph_pkg::SIZE_BITS'(amount_i);
              rem_d     = fph_pkg::REM_W'(fph_pkg::SIZE_BITS'(amount_i));
            end else begin
              rem_d     = '0;
            end
          end else if (stopped_q) begin
            // Refuse without touching the table
            out_valid_d = 1'b1;
            status_d    = fph_pkg::STAT_REFUSED;
            hole_d      = '0;
            rem_d       = '0;
            frag_d      = '0;
          end else begin
            scan_start = 1'b1;
            rd_cnt_d   = '0;
            state_d    = fph_pkg::ST_SCAN;
          end
        end
      end

      fph_pkg::ST_SCAN: begin
        // Issue one read per cycle, then drain the last beat into the scan unit
        if (rd_cnt_q != used_q) begin
          rd_en    = 1'b1;
          rd_cnt_d = rd_cnt_q + fph_pkg::CNT_W'(1);
        end else if (!rd_vld_q) begin
          state_d = fph_pkg::ST_FINISH;
        end
      end

      fph_pkg::ST_FINISH: begin
        // Hold the verdict until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = fph_pkg::ST_IDLE;
          if (fits) begin
            mem_we    = 1'b1;
            mem_waddr = res.pick;
            mem_wdata = shrunk;
            status_d  = fph_pkg::STAT_GRANTED;
            hole_d    = fph_pkg::HIDX_W'(res.pick);
            rem_d     = fph_pkg::REM_W'(shrunk);
            frag_d    = '0;
          end else begin
            stopped_d = 1'b1;
            status_d  = fph_pkg::STAT_NO_FIT;
            hole_d    = '0;
            rem_d     = '0;
            frag_d    = fph_pkg::frag_sat(res.sum);
          end
        end
      end

      default: state_d = fph_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fph_pkg::ST_IDLE;
      rd_cnt_q    <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= rd_en;
    end
  end

  // Configuration registers; hole count saturates at the table depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= fph_pkg::POL_FIRST;
      used_q   <= fph_pkg::CNT_W'(fph_pkg::USED_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fph_pkg::REG_POLICY: policy_q <= cfg_wdata_i[1:0];
        fph_pkg::REG_HOLE_COUNT: begin
          if (int'(cfg_wdata_i) > fph_pkg::MAX_HOLES) begin
            used_q <= fph_pkg::CNT_W'(fph_pkg::MAX_HOLES);
          end else begin
            used_q <= fph_pkg::CNT_W'(cfg_wdata_i);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= amount_i;
    end
    status_q <= status_d;
    hole_q   <= hole_d;
    rem_q    <= rem_d;
    frag_q   <= frag_d;
  end

  // Hole table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hole_mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= hole_mem_q[rd_cnt_q[fph_pkg::IDX_W-1:0]];
      rd_idx_q  <= rd_cnt_q[fph_pkg::IDX_W-1:0];
    end
  end

  assign beat = '{start: scan_start, vld: rd_vld_q, idx: rd_idx_q, size: rd_data_q};

  fph_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (beat),
    .policy_i (policy_q),
    .req_i    (req_q),
    .res_o    (res)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign chosen_hole_o    = hole_q;
  assign remaining_size_o = rem_q;
  assign fragmentation_o  = frag_q;

endmodule

// ----- design/fph_checker.sv -----
// Port-level checks for the fit-policy hole allocator, bound to the top level.
// Depends on fph_pkg.
module fph_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [fph_pkg::CMD_W-1:0]       command_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [fph_pkg::STAT_W-1:0]      status_o,
  input logic [fph_pkg::HIDX_W-1:0]      chosen_hole_o,
  input logic [fph_pkg::REM_W-1:0]       remaining_size_o,
  input logic [fph_pkg::FRAG_W-1:0]      fragmentation_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(chosen_hole_o) && $stable(remaining_size_o) && $stable(fragmentation_o))
    else $error("result beat changed while stalled");

  // Only a failed request reports fragmentation
  a_frag_only_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != fph_pkg::STAT_NO_FIT |-> fragmentation_o == '0)
    else $error("fragmentation set on a non-failing beat");

  // Failed and refused beats carry no hole
  a_no_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == fph_pkg::STAT_NO_FIT || status_o == fph_pkg::STAT_REFUSED)
    |-> chosen_hole_o == '0 && remaining_size_o == '0)
    else $error("hole reported on a failed or refused beat");

  // A scanning request occupies the sequencer; only a refusal answers at once
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i == fph_pkg::CMD_REQ |=>
    !in_ready_o || (out_valid_o && status_o == fph_pkg::STAT_REFUSED))
    else $error("item accepted right after a scanning request");

endmodule

bind fit_policy_hole_allocator fph_checker u_fph_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .command_i        (command_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .chosen_hole_o    (chosen_hole_o),
  .remaining_size_o (remaining_size_o),
  .fragmentation_o  (fragmentation_o)
);
